// ----- sv/utsc_pkg.sv -----
// ============================================================================
// utsc_pkg
// Shared widths and constants for the seconds-to-calendar converter.
// ============================================================================
package utsc_pkg;

    // Number of register stages from the input beat to the output register.
    localparam int unsigned STAGES = 8;

    // Field widths of the intermediate values.
    localparam int unsigned CNT_W  = 32;   // seconds since the epoch
    localparam int unsigned DAYS_W = 16;   // whole days since the epoch
    localparam int unsigned SOD_W  = 17;   // second of the day

    // Calendar constants.
    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned EPOCH_JDN     = 2440588;
    localparam int unsigned FAT_YEAR_BASE = 1980;

    // Output field widths.
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned MDAY_W  = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned WDAY_W  = 3;
    localparam int unsigned FAT_W   = 32;

    // Packed widths of the stream data buses.
    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 80;

endpackage

// ----- sv/utsc_pipe_ctrl.sv -----
// ============================================================================
// utsc_pipe_ctrl
// Valid bits and per-stage load enables for the converter pipeline. A stage
// loads when it is empty or when the stage after it loads, so bubbles
// collapse and a stall at the output holds every full stage in place.
// ============================================================================
module utsc_pipe_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,   // upstream beat offered
    output logic                         o_ready,   // upstream beat taken
    output logic                         o_valid,   // output register full
    input  logic                         i_ready,   // downstream takes beat
    output logic [utsc_pkg::STAGES-1:0]  o_en       // stage load enables
);

    logic [utsc_pkg::STAGES-1:0] r_valid;
    logic [utsc_pkg::STAGES-1:0] n_valid;
    logic [utsc_pkg::STAGES-1:0] en;

    // Load enables ripple back from the output register.
    always_comb begin
        en[utsc_pkg::STAGES-1] = !r_valid[utsc_pkg::STAGES-1] || i_ready;
        for (int k = utsc_pkg::STAGES - 2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    // Valid bits follow the data through each stage that loads.
    always_comb begin
        n_valid[0] = en[0] ? i_valid : r_valid[0];
        for (int k = 1; k < utsc_pkg::STAGES; k++) begin
            n_valid[k] = en[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_valid[utsc_pkg::STAGES-1];
    assign o_en    = en;

    // Reset empties the whole pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_valid == '0))
        else $error("pipeline not empty after reset");

    // Upstream is held off only when every stage holds a beat.
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_valid))
        else $error("input stalled while a stage is empty");

    // Beats in flight change only by what enters and what leaves.
    a_beat_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 ($countones(r_valid) + $past(int'(o_valid && i_ready)) ==
             $past($countones(r_valid)) + $past(int'(i_valid && o_ready))))
        else $error("beat lost or duplicated in the pipeline");

endmodule

// ----- sv/utsc_tod.sv -----
// ============================================================================
// utsc_tod
// Time-of-day path: splits the second of the day into hours, minutes and
// seconds with reciprocal multiplies, over pipeline stages two to seven.
// ============================================================================
module utsc_tod (
    input  logic                          i_clk,
    input  logic [utsc_pkg::STAGES-1:0]   i_en,
    input  logic [utsc_pkg::SOD_W-1:0]    i_sod,
    output logic [utsc_pkg::HOUR_W-1:0]   o_hours,
    output logic [utsc_pkg::MIN_W-1:0]    o_minutes,
    output logic [utsc_pkg::SEC_W-1:0]    o_seconds
);

    // sod / 60 is (sod >> 2) / 15: 15-bit dividend, 4-bit divisor.
    localparam int unsigned    MT_SHIFT = 19;
    localparam logic [15:0]    MT_MUL   = 16'(((64'd1 << MT_SHIFT) + 64'd14) / 64'd15);
    // minutes / 60 is (minutes >> 2) / 15: 9-bit dividend.
    localparam int unsigned    HR_SHIFT = 13;
    localparam logic [9:0]     HR_MUL   = 10'(((64'd1 << HR_SHIFT) + 64'd14) / 64'd15);

    logic [30:0]                  r2_pq;
    logic [utsc_pkg::SOD_W-1:0]   r2_sod;
    logic [10:0]                  r3_mt;
    logic [utsc_pkg::SEC_W-1:0]   r3_sec;
    logic [18:0]                  r4_ph;
    logic [10:0]                  r4_mt;
    logic [utsc_pkg::SEC_W-1:0]   r4_sec;
    logic [utsc_pkg::HOUR_W-1:0]  r5_hours, r6_hours, r7_hours;
    logic [utsc_pkg::MIN_W-1:0]   r5_min, r6_min, r7_min;
    logic [utsc_pkg::SEC_W-1:0]   r5_sec, r6_sec, r7_sec;

    logic [10:0]                  mt;
    logic [utsc_pkg::HOUR_W-1:0]  hrs;

    assign mt  = r2_pq[29:19];
    assign hrs = r4_ph[17:13];

    // Stage two: reciprocal product for the minute of the day.
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r2_pq  <= 31'(31'(i_sod[16:2]) * 31'(MT_MUL));
            r2_sod <= i_sod;
        end
    end

    // Stage three: minute of the day and the seconds remainder.
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r3_mt  <= mt;
            r3_sec <= 6'(r2_sod - 17'(17'(mt) * 17'd60));
        end
    end

    // Stage four: reciprocal product for the hour.
    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r4_ph  <= 19'(19'(r3_mt[10:2]) * 19'(HR_MUL));
            r4_mt  <= r3_mt;
            r4_sec <= r3_sec;
        end
    end

    // Stage five: hour and minute of the hour.
    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r5_hours <= hrs;
            r5_min   <= 6'(r4_mt - 11'(11'(hrs) * 11'd60));
            r5_sec   <= r4_sec;
        end
    end

    // Stages six and seven: delay to line up with the date path.
    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r6_hours <= r5_hours;
            r6_min   <= r5_min;
            r6_sec   <= r5_sec;
        end
        if (i_en[7]) begin
            r7_hours <= r6_hours;
            r7_min   <= r6_min;
            r7_sec   <= r6_sec;
        end
    end

    assign o_hours   = r7_hours;
    assign o_minutes = r7_min;
    assign o_seconds = r7_sec;

endmodule

// ----- sv/utsc_date.sv -----
// ============================================================================
// utsc_date
// Date path: turns the day count into weekday and Gregorian year, month and
// day through the integer Julian-day steps, over pipeline stages two to seven.
// ============================================================================
module utsc_date (
    input  logic                           i_clk,
    input  logic [utsc_pkg::STAGES-1:0]    i_en,
    input  logic [utsc_pkg::DAYS_W-1:0]    i_days,
    output logic [utsc_pkg::YEAR_W-1:0]    o_year,
    output logic [utsc_pkg::MONTH_W-1:0]   o_month,
    output logic [utsc_pkg::MDAY_W-1:0]    o_mday,
    output logic [utsc_pkg::WDAY_W-1:0]    o_weekday
);

    // Julian day plus the algorithm's 32044 offset.
    localparam logic [21:0] JD_OFFSET = 22'(utsc_pkg::EPOCH_JDN + 32044);
    // Weekday of the epoch day, Monday being zero.
    localparam logic [15:0] WD_BIAS   = 16'(utsc_pkg::EPOCH_JDN % 7);
    localparam logic [13:0] YEAR_BIAS = 14'd4800;

    // Reciprocals: (4a+3)/146097, (days+bias)/7, (4c+3)/1461, (5e+2)/153.
    localparam int unsigned B_SHIFT = 42;
    localparam logic [24:0] B_MUL   =
        25'(((64'd1 << B_SHIFT) + 64'd146096) / 64'd146097);
    localparam int unsigned W_SHIFT = 19;
    localparam logic [16:0] W_MUL   = 17'(((64'd1 << W_SHIFT) + 64'd6) / 64'd7);
    localparam int unsigned D_SHIFT = 29;
    localparam logic [18:0] D_MUL   = 19'(((64'd1 << D_SHIFT) + 64'd1460) / 64'd1461);
    localparam int unsigned M_SHIFT = 19;
    localparam logic [11:0] M_MUL   = 12'(((64'd1 << M_SHIFT) + 64'd152) / 64'd153);

    // First day of each month, counted from March 1st, as (153m+2)/5.
    function automatic logic [8:0] f_month_start(input logic [3:0] m);
        logic [8:0] s;
        unique case (m)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    logic [21:0]                   r2_a;
    logic [48:0]                   r2_pb;
    logic [15:0]                   r2_wx;
    logic [32:0]                   r2_pw;
    logic [6:0]                    r3_b, r4_b, r5_b, r6_b;
    logic [15:0]                   r3_c, r4_c;
    logic [utsc_pkg::WDAY_W-1:0]   r3_wd, r4_wd, r5_wd, r6_wd, r7_wd;
    logic [36:0]                   r4_pd;
    logic [6:0]                    r5_d, r6_d;
    logic [8:0]                    r5_e, r6_e;
    logic [22:0]                   r6_pm;
    logic [utsc_pkg::YEAR_W-1:0]   r7_year;
    logic [utsc_pkg::MONTH_W-1:0]  r7_month;
    logic [utsc_pkg::MDAY_W-1:0]   r7_mday;

    logic [21:0]  jd_a;
    logic [15:0]  wd_x;
    logic [6:0]   b;
    logic [13:0]  wq;
    logic [6:0]   d;
    logic [10:0]  xm;
    logic [3:0]   m;
    logic         m_wrap;
    logic [8:0]   mday9;
    logic [13:0]  year14;

    assign jd_a   = 22'(i_days) + JD_OFFSET;
    assign wd_x   = i_days + WD_BIAS;
    assign b      = r2_pb[48:42];
    assign wq     = r2_pw[32:19];
    assign d      = r4_pd[35:29];
    assign xm     = 11'(11'(r5_e) * 11'd5 + 11'd2);
    assign m      = r6_pm[22:19];
    assign m_wrap = (m >= 4'd10);
    assign mday9  = r6_e - f_month_start(m) + 9'd1;
    assign year14 = 14'(14'(r6_b) * 14'd100) + 14'(r6_d) + 14'(m_wrap) - YEAR_BIAS;

    // Stage two: shifted day number and the century and weekday products.
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r2_a  <= jd_a;
            r2_pb <= 49'(49'({jd_a, 2'b11}) * 49'(B_MUL));
            r2_wx <= wd_x;
            r2_pw <= 33'(33'(wd_x) * 33'(W_MUL));
        end
    end

    // Stage three: century count, day within the century, weekday.
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r3_b  <= b;
            r3_c  <= 16'(r2_a - 22'(25'(25'(b) * 25'd146097) >> 2));
            r3_wd <= 3'(r2_wx - 16'(16'(wq) * 16'd7));
        end
    end

    // Stage four: reciprocal product for the year within the century.
    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r4_pd <= 37'(37'({r3_c, 2'b11}) * 37'(D_MUL));
            r4_c  <= r3_c;
            r4_b  <= r3_b;
            r4_wd <= r3_wd;
        end
    end

    // Stage five: year within the century and day within that year.
    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r5_d  <= d;
            r5_e  <= 9'(r4_c - 16'(18'(18'(d) * 18'd1461) >> 2));
            r5_b  <= r4_b;
            r5_wd <= r4_wd;
        end
    end

    // Stage six: reciprocal product for the March-based month.
    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r6_pm <= 23'(23'(xm) * 23'(M_MUL));
            r6_e  <= r5_e;
            r6_d  <= r5_d;
            r6_b  <= r5_b;
            r6_wd <= r5_wd;
        end
    end

    // Stage seven: month, day of month and year.
    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r7_month <= m_wrap ? 4'(m - 4'd9) : 4'(m + 4'd3);
            r7_mday  <= mday9[4:0];
            r7_year  <= year14[11:0];
            r7_wd    <= r6_wd;
        end
    end

    assign o_year    = r7_year;
    assign o_month   = r7_month;
    assign o_mday    = r7_mday;
    assign o_weekday = r7_wd;

endmodule

// ----- sv/unix_seconds_to_calendar.sv -----
// ============================================================================
// unix_seconds_to_calendar
// Converts a count of seconds since 1970-01-01 00:00:00 into Gregorian date,
// time of day, weekday (0 = Monday) and a packed FAT timestamp.
//
// The converter takes one beat per clock cycle while the input is not held
// off, and returns one beat for each beat taken, in order. Each beat passes
// through the eight register stages of the pipeline: each stage holds one
// constant-reciprocal multiply or the subtract and select that follows it.
// A stall at the output holds the full stages and lets empty ones fill, so
// the input keeps taking beats until all eight stages are occupied. The FAT
// year field is (year - 1980) mod 128 and its seconds field is seconds / 2,
// rounded down.
// ============================================================================
module unix_seconds_to_calendar (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] counter_seconds
    input  logic [utsc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hours,
    // [31:26] minutes, [37:32] seconds, [40:38] weekday, [72:41] fat_stamp,
    // [79:73] zero
    output logic [utsc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    // Days are (seconds >> 7) / 675; 25-bit dividend, 10-bit divisor.
    localparam int unsigned DAY_PRESHIFT = 7;
    localparam int unsigned DAY_DIVISOR  = utsc_pkg::SECS_PER_DAY / (2 ** DAY_PRESHIFT);
    localparam int unsigned DAY_SHIFT    = 35;
    localparam logic [25:0] DAY_MUL      =
        26'(((64'd1 << DAY_SHIFT) + 64'(DAY_DIVISOR) - 64'd1) / 64'(DAY_DIVISOR));

    logic [utsc_pkg::STAGES-1:0]    en;
    logic [utsc_pkg::CNT_W-1:0]     r0_cnt;
    logic [50:0]                    r0_prod;
    logic [utsc_pkg::DAYS_W-1:0]    r1_days;
    logic [utsc_pkg::SOD_W-1:0]     r1_sod;
    logic [utsc_pkg::DAYS_W-1:0]    days;

    logic [utsc_pkg::YEAR_W-1:0]    year;
    logic [utsc_pkg::MONTH_W-1:0]   month;
    logic [utsc_pkg::MDAY_W-1:0]    mday;
    logic [utsc_pkg::WDAY_W-1:0]    weekday;
    logic [utsc_pkg::HOUR_W-1:0]    hours;
    logic [utsc_pkg::MIN_W-1:0]     minutes;
    logic [utsc_pkg::SEC_W-1:0]     seconds;
    logic [utsc_pkg::FAT_W-1:0]     fat_stamp;
    logic [6:0]                     fat_year;

    // Valid bits and stage enables.
    utsc_pipe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_en    (en)
    );

    // Stage zero: take the beat and form the day reciprocal product.
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_cnt  <= s_axis_tdata[utsc_pkg::CNT_W-1:0];
            r0_prod <= 51'(51'(s_axis_tdata[31:DAY_PRESHIFT]) * 51'(DAY_MUL));
        end
    end

    assign days = r0_prod[50:35];

    // Stage one: whole days and the second of the day.
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_days <= days;
            r1_sod  <= 17'(r0_cnt - 32'(32'(days) * 32'(utsc_pkg::SECS_PER_DAY)));
        end
    end

    utsc_tod u_tod (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_sod     (r1_sod),
        .o_hours   (hours),
        .o_minutes (minutes),
        .o_seconds (seconds)
    );

    utsc_date u_date (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_days    (r1_days),
        .o_year    (year),
        .o_month   (month),
        .o_mday    (mday),
        .o_weekday (weekday)
    );

    // FAT timestamp packing from the output register fields.
    assign fat_year  = 7'(year - 12'(utsc_pkg::FAT_YEAR_BASE));
    assign fat_stamp = {fat_year, month, mday, hours, minutes, seconds[5:1]};

    assign m_axis_tdata = {7'd0, fat_stamp, weekday, seconds, minutes, hours,
                           mday, month, year};

    // Every beat shown at the output is a real calendar time.
    a_out_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (month >= 4'd1 && month <= 4'd12 && mday >= 5'd1 &&
                           hours < 5'd24 && minutes < 6'd60 && seconds < 6'd60 &&
                           weekday < 3'd7))
        else $error("calendar field out of range");

    // The year stays within the span of a 32-bit seconds count.
    a_year_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (year >= 12'd1970 && year <= 12'd2106))
        else $error("year outside the 32-bit epoch span");

endmodule
